// ===== sv/coordinate_system_converter_macros.svh =====
// Assertion macros shared by the coordinate converter modules.
`ifndef COORDINATE_SYSTEM_CONVERTER_MACROS_SVH
`define COORDINATE_SYSTEM_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define CSC_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define CSC_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define CSC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CSC_CHECK(lbl, expr, msg)
`define CSC_CHECK_IMP(lbl, ante, cons, msg)
`define CSC_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/csc_pkg.sv =====
// Shared types, codes, constants and tables of the coordinate converter.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;

	localparam int DATA_WIDTH   = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int GUARD        = (DATA_WIDTH - 16) / 2;
	localparam int ATAN_COUNT   = 40;
	localparam int STEPS        = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

	// internal length width: Q16.16 plus guard bits plus CORDIC growth headroom
	localparam int W  = 32 + GUARD + 4;
	localparam int ZW = 34;

	// registers per CORDIC pass: pre, two multiply, iterations, two multiply
	localparam int PASS_LAT = STEPS + 5;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] THETA_WRAP   = 32'hC000_0000;

	localparam logic [1:0] SYS_CART = 2'd0;
	localparam logic [1:0] SYS_CYL  = 2'd1;
	localparam logic [1:0] SYS_SPH  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NEG_RHO = 2'd1;
	localparam logic [1:0] ST_THETA   = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;

	localparam logic [2:0] OP_PASS = 3'd0;
	localparam logic [2:0] OP_ERR  = 3'd1;
	localparam logic [2:0] OP_C2Y  = 3'd2;
	localparam logic [2:0] OP_C2S  = 3'd3;
	localparam logic [2:0] OP_Y2C  = 3'd4;
	localparam logic [2:0] OP_Y2S  = 3'd5;
	localparam logic [2:0] OP_S2C  = 3'd6;
	localparam logic [2:0] OP_S2Y  = 3'd7;

	localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};

	// 1/K in Q0.32: 2^62 / isqrt(prod(1 + 4^-i) in Q60), evaluated at elaboration
	function automatic logic [63:0] calc_kinv();
		logic [63:0] g2;
		logic [63:0] num;
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] k;
		logic [63:0] rem;
		logic [63:0] quo;
		int i;
		int j;
		int b;
		g2 = 64'd1 << 60;
		for (i = 0; i < STEPS; i++) begin
			if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
		end
		num = g2;
		res = '0;
		bv  = 64'd1 << 62;
		for (j = 0; j < 32; j++) begin
			if (num >= res + bv) begin
				num = num - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		k = (res == '0) ? 64'd1 : res;
		rem = '0;
		quo = '0;
		for (b = 62; b >= 0; b--) begin
			rem = (rem << 1) | ((b == 62) ? 64'd1 : 64'd0);
			if (rem >= k) begin
				rem = rem - k;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	localparam logic [63:0] KINV_FULL = calc_kinv();
	localparam logic [31:0] KINV      = KINV_FULL[31:0];

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  st;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} item_t;

endpackage
`default_nettype wire

// ===== sv/coordinate_system_converter.sv =====
// Top level of the Cartesian / cylindrical / spherical coordinate converter.
//
//  channel  dir  signals                             contents (lowest bits first)
//  s_*      in   s_tvalid s_tready s_tdata s_tuser   tdata: in_a in_b in_c; tuser: src, tgt
//  m_*      out  m_tvalid m_tready m_tdata m_tuser   tdata: out_a out_b out_c; tuser: status
//
// One item per cycle is sustained while m_tready stays high; the two 29-stage CORDIC passes
// (CORDIC_STEPS + 5 each) run one after the other and feed the output register.
// Reset (arst_n low) empties the queue and clears all valid bits; no clearing pass.
// m_tready low while a result waits freezes the back end; the 4-entry queue keeps taking items until full,
// then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module coordinate_system_converter import csc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // in_a, in_b, in_c
	input  logic [3:0]  s_tuser,  // source_system, target_system
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // out_a, out_b, out_c
	output logic [1:0]  m_tuser   // status
);

	item_t front_item;
	item_t head;
	logic  q_valid;
	logic  q_pop;

	csc_front u_front (
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.item    (front_item)
	);

	csc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_item (front_item),
		.ready     (s_tready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head)
	);

	csc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== sv/csc_front.sv =====
// Front end: decodes the systems, checks the input vector, picks the operation.
`timescale 1ns / 1ps
`default_nettype none
module csc_front import csc_pkg::*; (
	input  logic [95:0] s_tdata,  // in_a, in_b, in_c
	input  logic [3:0]  s_tuser,  // source_system, target_system
	output item_t       item
);

	logic [1:0] src;
	logic [1:0] tgt;
	logic [1:0] st;
	logic [2:0] op;

	always_comb begin
		// unused code 3 reads as cartesian
		src = (s_tuser[1:0] == 2'd3) ? SYS_CART : s_tuser[1:0];
		tgt = (s_tuser[3:2] == 2'd3) ? SYS_CART : s_tuser[3:2];
		st = ST_OK;
		if (src == SYS_CYL && s_tdata[63]) st = ST_NEG_RHO;
		if (src == SYS_SPH && s_tdata[63:32] > HALF_TURN) st = ST_THETA;
		op = OP_PASS;
		if (st != ST_OK) begin
			op = OP_ERR;
		end else if (src != tgt) begin
			unique case (src)
				SYS_CART: op = (tgt == SYS_CYL) ? OP_C2Y : OP_C2S;
				SYS_CYL:  op = (tgt == SYS_CART) ? OP_Y2C : OP_Y2S;
				default:  op = (tgt == SYS_CART) ? OP_S2C : OP_S2Y;
			endcase
		end
		item.op = op;
		item.st = st;
		item.a  = s_tdata[31:0];
		item.b  = s_tdata[63:32];
		item.c  = s_tdata[95:64];
	end

endmodule
`default_nettype wire

// ===== sv/csc_queue.sv =====
// Short queue that decouples the front end from the CORDIC back end.
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_system_converter_macros.svh"
module csc_queue import csc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  ready,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;

	assign ready = (count_q != (QAW+1)'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	`CSC_CHECK(q_count_range, count_q <= (QAW+1)'(QDEPTH), "queue count beyond depth")
	`CSC_CHECK_NEXT(q_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue lost a push")

endmodule
`default_nettype wire

// ===== sv/csc_cordic.sv =====
// One pipelined CORDIC pass: vectoring or rotation chosen per item, with gain correction.
`timescale 1ns / 1ps
`default_nettype none
module csc_cordic import csc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic                mode_vec,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic [31:0]         ang_in,
	output logic signed [W-1:0] x_out,
	output logic signed [W-1:0] y_out,
	output logic [ZW-1:0]       z_out
);

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	// pre stage
	logic                vec_s1, skip_s1;
	logic signed [W-1:0] x_s1, y_s1;
	logic [ZW-1:0]       z_s1;
	// first multiply stage
	logic                vec_s2, skip_s2, neg_s2;
	logic signed [W-1:0] x_s2, y_s2;
	logic [ZW-1:0]       z_s2;
	logic [W-1:0]        hp_s2;
	logic [63:0]         lp_s2;
	// iteration stages
	logic signed [W-1:0] cx_s [0:STEPS];
	logic signed [W-1:0] cy_s [0:STEPS];
	logic [ZW-1:0]       cz_s [0:STEPS];
	logic                cv_s [0:STEPS];
	logic                ck_s [0:STEPS];
	// post multiply stages
	logic                vec_s5, skip_s5, neg_s5;
	logic signed [W-1:0] x_s5, y_s5;
	logic [ZW-1:0]       z_s5;
	logic [W-1:0]        hp_s5;
	logic [63:0]         lp_s5;
	logic signed [W-1:0] x_s6, y_s6;
	logic [ZW-1:0]       z_s6;

	logic                pre_skip;
	logic signed [W-1:0] pre_x, pre_y;
	logic [ZW-1:0]       pre_z;
	logic [31:0]         qsum, rang;
	logic [W-1:0]        mag1, mag5, r2, r5;

	always_comb begin
		qsum = ang_in + QUARTER_TURN;
		rang = qsum[31] ? ang_in + HALF_TURN : ang_in;
		pre_skip = 1'b0;
		if (mode_vec) begin
			pre_y = y_in;
			pre_x = x_in;
			pre_z = '0;
			if (y_in == '0) begin
				// atan2(0, x): exact magnitude, angle 0 or half a turn
				pre_skip = 1'b1;
				pre_x = $signed(mag(x_in));
				pre_z = {2'b00, x_in[W-1] ? HALF_TURN : 32'd0};
			end else if (x_in[W-1]) begin
				pre_x = -x_in;
				pre_y = -y_in;
				pre_z = {2'b00, HALF_TURN};
			end
		end else begin
			// fold the angle into the right half plane
			pre_x = qsum[31] ? -x_in : x_in;
			pre_y = '0;
			pre_z = {{(ZW-32){rang[31]}}, rang};
		end
		mag1 = mag(x_s1);
		mag5 = mag(cx_s[STEPS]);
		r2 = hp_s2 + W'(lp_s2[63:32]);
		r5 = hp_s5 + W'(lp_s5[63:32]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1  <= mode_vec;
			skip_s1 <= pre_skip;
			x_s1    <= pre_x;
			y_s1    <= pre_y;
			z_s1    <= pre_z;

			vec_s2  <= vec_s1;
			skip_s2 <= skip_s1;
			neg_s2  <= x_s1[W-1];
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			hp_s2   <= W'(mag1[W-1:32]) * W'(KINV);
			lp_s2   <= 64'(mag1[31:0]) * 64'(KINV);

			// rotation starts from the gain-corrected length
			cx_s[0] <= vec_s2 ? x_s2 : $signed(neg_s2 ? ~r2 + 1'b1 : r2);
			cy_s[0] <= y_s2;
			cz_s[0] <= z_s2;
			cv_s[0] <= vec_s2;
			ck_s[0] <= skip_s2;

			vec_s5  <= cv_s[STEPS];
			skip_s5 <= ck_s[STEPS];
			neg_s5  <= cx_s[STEPS][W-1];
			x_s5    <= cx_s[STEPS];
			y_s5    <= cy_s[STEPS];
			z_s5    <= cz_s[STEPS];
			hp_s5   <= W'(mag5[W-1:32]) * W'(KINV);
			lp_s5   <= 64'(mag5[31:0]) * 64'(KINV);

			// vectoring corrects the magnitude at the end
			x_s6 <= (vec_s5 && !skip_s5) ? $signed(neg_s5 ? ~r5 + 1'b1 : r5) : x_s5;
			y_s6 <= y_s5;
			z_s6 <= z_s5;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		logic up;
		assign up = cv_s[i] ? cy_s[i][W-1] : !cz_s[i][ZW-1];
		always_ff @(posedge clk) begin
			if (en) begin
				cv_s[i+1] <= cv_s[i];
				ck_s[i+1] <= ck_s[i];
				if (ck_s[i]) begin
					cx_s[i+1] <= cx_s[i];
					cy_s[i+1] <= cy_s[i];
					cz_s[i+1] <= cz_s[i];
				end else if (up) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ZW'(ATAN_TAB[i]);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ZW'(ATAN_TAB[i]);
				end
			end
		end
	end

	assign x_out = x_s6;
	assign y_out = y_s6;
	assign z_out = z_s6;

endmodule
`default_nettype wire

// ===== sv/csc_back.sv =====
// Back end: two CORDIC passes, result assembly, rounding, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_system_converter_macros.svh"
module csc_back import csc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_head,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // out_a, out_b, out_c
	output logic [1:0]  m_tuser   // status
);

	localparam int RW = W + 1 - GUARD;

	typedef struct packed {
		logic [2:0]          op;
		logic [1:0]          st;
		logic [31:0]         a;
		logic [31:0]         b;
		logic [31:0]         c;
		logic signed [W-1:0] p1x;
		logic signed [W-1:0] p1y;
		logic [31:0]         p1z;
	} side2_t;

	typedef struct packed {
		logic [31:0] v;
		logic        sat;
	} emit_t;

	function automatic logic signed [W-1:0] scale(input logic [31:0] v);
		return $signed({{(W-32-GUARD){v[31]}}, v, {GUARD{1'b0}}});
	endfunction

	// round half up, drop the guard bits, saturate to 32 bits
	function automatic emit_t emit(input logic signed [W-1:0] v);
		logic signed [W:0]    t;
		logic signed [RW-1:0] r;
		emit_t                e;
		t = {v[W-1], v} + (W+1)'((1 << GUARD) >> 1);
		r = RW'(t >>> GUARD);
		e.sat = !((&r[RW-1:31]) || !(|r[RW-1:31]));
		e.v = e.sat ? (r[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r[31:0];
		return e;
	endfunction

	function automatic logic [31:0] clamp_theta(input logic [31:0] t);
		if (t > THETA_WRAP) return 32'd0;
		if (t > HALF_TURN) return HALF_TURN;
		return t;
	endfunction

	logic                adv;
	logic                vl_q [0:2*PASS_LAT-1];
	item_t               l1_q [0:PASS_LAT-1];
	side2_t              l2_q [0:PASS_LAT-1];
	logic                out_v_q;
	logic [95:0]         out_d_q;
	logic [1:0]          out_u_q;

	logic                vec1, vec2;
	logic signed [W-1:0] x1, y1, x2, y2;
	logic [31:0]         ang1;
	logic signed [W-1:0] x1o, y1o, x2o, y2o;
	logic [ZW-1:0]       z1o, z2o;
	item_t               d1;
	side2_t              d2, s2in;

	logic signed [W-1:0] sel_a, sel_b, sel_c;
	logic                use_b, use_c;
	logic [31:0]         raw_b, raw_c;
	emit_t               ea, eb, ec;
	logic [95:0]         res_d;
	logic [1:0]          res_u;

	// the whole back end advances unless a finished item waits at the output with m_tready low
	assign adv   = !out_v_q || m_tready;
	assign q_pop = adv && q_valid;

	always_comb begin
		vec1 = (q_head.op == OP_C2Y) || (q_head.op == OP_C2S) || (q_head.op == OP_Y2S);
		x1   = scale((q_head.op == OP_Y2C) ? q_head.b : q_head.a);
		y1   = scale(q_head.b);
		ang1 = (q_head.op == OP_Y2C) ? q_head.c : q_head.b;

		d1   = l1_q[PASS_LAT-1];
		vec2 = (d1.op == OP_C2S);
		x2   = vec2 ? scale(d1.c) : y1o;
		y2   = x1o;

		s2in.op  = d1.op;
		s2in.st  = d1.st;
		s2in.a   = d1.a;
		s2in.b   = d1.b;
		s2in.c   = d1.c;
		s2in.p1x = x1o;
		s2in.p1y = y1o;
		s2in.p1z = z1o[31:0];
	end

	csc_cordic u_pass1 (
		.clk      (clk),
		.en       (adv),
		.mode_vec (vec1),
		.x_in     (x1),
		.y_in     (y1),
		.ang_in   (ang1),
		.x_out    (x1o),
		.y_out    (y1o),
		.z_out    (z1o)
	);

	csc_cordic u_pass2 (
		.clk      (clk),
		.en       (adv),
		.mode_vec (vec2),
		.x_in     (x2),
		.y_in     (y2),
		.ang_in   (d1.c),
		.x_out    (x2o),
		.y_out    (y2o),
		.z_out    (z2o)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			l1_q[0] <= q_head;
			l2_q[0] <= s2in;
			for (int k = 1; k < PASS_LAT; k++) begin
				l1_q[k] <= l1_q[k-1];
				l2_q[k] <= l2_q[k-1];
			end
		end
	end

	always_comb begin
		d2    = l2_q[PASS_LAT-1];
		sel_a = d2.p1x;
		sel_b = d2.p1y;
		sel_c = scale(d2.a);
		use_b = 1'b1;
		use_c = 1'b0;
		raw_b = d2.b;
		raw_c = d2.c;
		unique case (d2.op)
			OP_C2Y: begin
				sel_a = scale(d2.c);
				sel_b = d2.p1x;
				raw_c = d2.p1z;
			end
			OP_C2S: begin
				sel_a = x2o;
				use_b = 1'b0;
				raw_b = clamp_theta(z2o[31:0]);
				raw_c = d2.p1z;
			end
			OP_Y2C: begin
				use_c = 1'b1;
			end
			OP_Y2S: begin
				use_b = 1'b0;
				raw_b = clamp_theta(d2.p1z);
			end
			OP_S2C: begin
				sel_a = x2o;
				sel_b = y2o;
				sel_c = d2.p1x;
				use_c = 1'b1;
			end
			OP_S2Y: begin
			end
			OP_PASS: begin
			end
			OP_ERR: begin
			end
		endcase
		ea = emit(sel_a);
		eb = emit(sel_b);
		ec = emit(sel_c);
		res_d = {use_c ? ec.v : raw_c, use_b ? eb.v : raw_b, ea.v};
		res_u = (ea.sat || (use_b && eb.sat) || (use_c && ec.sat)) ? ST_SAT : ST_OK;
		if (d2.op == OP_PASS) begin
			res_d = {d2.c, d2.b, d2.a};
			res_u = ST_OK;
		end else if (d2.op == OP_ERR) begin
			res_d = '0;
			res_u = d2.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			for (int k = 0; k < 2*PASS_LAT; k++) vl_q[k] <= 1'b0;
		end else if (adv) begin
			vl_q[0] <= q_pop;
			for (int k = 1; k < 2*PASS_LAT; k++) vl_q[k] <= vl_q[k-1];
			out_v_q <= vl_q[2*PASS_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d_q <= res_d;
			out_u_q <= res_u;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_u_q;

	`CSC_CHECK_IMP(b_err_zero, out_v_q && (out_u_q == ST_NEG_RHO || out_u_q == ST_THETA), out_d_q == '0, "error item carries data")
	`CSC_CHECK_NEXT(b_stall_hold, out_v_q && !m_tready, $stable(vl_q[2*PASS_LAT-1]), "pipeline moved during stall")

endmodule
`default_nettype wire
